@@ hdl/bgtl_pkg.sv @@
// bilinear gain table lookup: shared types, field widths and register codes
// no dependencies; imported by every module of the block
`default_nettype none

package bgtl_pkg;

	// fixed field widths of the stream items
	localparam int DIR_W      = 16;
	localparam int INV_W      = 24;
	localparam int GRID_W     = 7;
	localparam int CTR_W      = 6;
	localparam int WIDX_W     = 6;
	localparam int IN_GAIN_W  = 16;
	localparam int OUT_GAIN_W = 16;

	// position product and cell index widths
	localparam int POS_FRAC = 23;
	localparam int MAG_W    = DIR_W + INV_W;
	localparam int CELL_W   = MAG_W - POS_FRAC + 1;
	localparam int IDX_W    = CELL_W + 2;

	// stream packing
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OOR_GAIN      = 3'd6;

	localparam logic [GRID_W-1:0]     RST_GRID     = 7'd64;
	localparam logic [CTR_W-1:0]      RST_CENTER   = 6'd32;
	localparam logic [INV_W-1:0]      RST_INV      = 24'd256;
	localparam logic [OUT_GAIN_W-1:0] RST_OOR_GAIN = 16'd0;

	// operation codes carried in tuser
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// per-item control flags travelling down the pipeline
	typedef struct packed {
		logic query;
		logic outside;
		logic wr_ok;
	} stage_ctl_t;

endpackage

`default_nettype wire

@@ hdl/bgtl_front.sv @@
// front stages: direction times reciprocal spacing, then floor, centre offset and range check
// depends on bgtl_pkg
`default_nettype none

module bgtl_front #(
	parameter int MAX_COLS      = 64,
	parameter int MAX_ROWS      = 64,
	parameter int GAIN_BITS     = 16,
	parameter int FRACTION_BITS = 12,
	localparam int COL_W        = $clog2(MAX_COLS),
	localparam int ROW_W        = $clog2(MAX_ROWS)
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   in_op,
	input  wire  [bgtl_pkg::WIDX_W-1:0]           in_col,
	input  wire  [bgtl_pkg::WIDX_W-1:0]           in_row,
	input  wire  [bgtl_pkg::IN_GAIN_W-1:0]        in_gain,
	input  wire  signed [bgtl_pkg::DIR_W-1:0]     in_dir_x,
	input  wire  signed [bgtl_pkg::DIR_W-1:0]     in_dir_y,
	input  wire  [bgtl_pkg::GRID_W-1:0]           grid_width,
	input  wire  [bgtl_pkg::GRID_W-1:0]           grid_height,
	input  wire  [bgtl_pkg::CTR_W-1:0]            center_x,
	input  wire  [bgtl_pkg::CTR_W-1:0]            center_y,
	input  wire  [bgtl_pkg::INV_W-1:0]            inv_spacing_x,
	input  wire  [bgtl_pkg::INV_W-1:0]            inv_spacing_y,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output bgtl_pkg::stage_ctl_t                  out_ctl,
	output logic [COL_W-1:0]                      out_ix,
	output logic [ROW_W-1:0]                      out_iy,
	output logic [FRACTION_BITS-1:0]              out_t,
	output logic [FRACTION_BITS-1:0]              out_u,
	output logic [bgtl_pkg::WIDX_W-1:0]           out_col,
	output logic [bgtl_pkg::WIDX_W-1:0]           out_row,
	output logic [GAIN_BITS-1:0]                  out_gain
);
	import bgtl_pkg::*;

	logic en_s1, en_s2;
	logic v_s1, v_s2;

	// stage 1 registers
	stage_ctl_t         ctl_s1;
	logic [MAG_W-1:0]   mag_x_s1, mag_y_s1;
	logic               neg_x_s1, neg_y_s1;
	logic [WIDX_W-1:0]  col_s1, row_s1;
	logic [GAIN_BITS-1:0] gain_s1;

	// stage 2 registers
	stage_ctl_t         ctl_s2;
	logic [COL_W-1:0]   ix_s2;
	logic [ROW_W-1:0]   iy_s2;
	logic [FRACTION_BITS-1:0] t_s2, u_s2;
	logic [WIDX_W-1:0]  col_s2, row_s2;
	logic [GAIN_BITS-1:0] gain_s2;

	logic [DIR_W-1:0]   abs_x, abs_y;
	logic [MAG_W-1:0]   prod_x, prod_y;
	logic               wr_ok;

	logic               cfg_ok;
	logic [CELL_W-1:0]  cell_x, cell_y;
	logic [POS_FRAC-1:0] frac_x, frac_y;
	logic signed [IDX_W-1:0] off_x, off_y, ix, iy;
	logic               out_x, out_y;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// floored cell magnitude: negative positions round away from zero
	function automatic logic [CELL_W-1:0] cell_of(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic rnd;
		rnd = neg && (mag[POS_FRAC-1:0] != '0);
		return CELL_W'(mag[MAG_W-1:POS_FRAC]) + CELL_W'(rnd);
	endfunction

	function automatic logic [POS_FRAC-1:0] frac_of(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic [POS_FRAC-1:0] lo;
		lo = mag[POS_FRAC-1:0];
		return neg ? (POS_FRAC'(0) - lo) : lo;
	endfunction

	// stage 1: magnitude product
	always_comb begin
		abs_x  = in_dir_x[DIR_W-1] ? DIR_W'(-in_dir_x) : DIR_W'(in_dir_x);
		abs_y  = in_dir_y[DIR_W-1] ? DIR_W'(-in_dir_y) : DIR_W'(in_dir_y);
		prod_x = MAG_W'(abs_x) * MAG_W'(inv_spacing_x);
		prod_y = MAG_W'(abs_y) * MAG_W'(inv_spacing_y);
		wr_ok  = (in_op == OP_WRITE) && (32'(in_col) < MAX_COLS) &&
			(32'(in_row) < MAX_ROWS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ctl_s1   <= '{query: (in_op == OP_QUERY), outside: 1'b0, wr_ok: wr_ok};
			mag_x_s1 <= prod_x;
			mag_y_s1 <= prod_y;
			neg_x_s1 <= in_dir_x[DIR_W-1];
			neg_y_s1 <= in_dir_y[DIR_W-1];
			col_s1   <= in_col;
			row_s1   <= in_row;
			gain_s1  <= GAIN_BITS'(in_gain);
		end
	end

	// stage 2: floor, offset by centre, range check
	always_comb begin
		cfg_ok = (grid_width != '0) && (32'(grid_width) <= MAX_COLS) &&
			(grid_height != '0) && (32'(grid_height) <= MAX_ROWS) &&
			(GRID_W'(center_x) < grid_width) && (GRID_W'(center_y) < grid_height);
		cell_x = cell_of(mag_x_s1, neg_x_s1);
		cell_y = cell_of(mag_y_s1, neg_y_s1);
		frac_x = frac_of(mag_x_s1, neg_x_s1);
		frac_y = frac_of(mag_y_s1, neg_y_s1);
		off_x  = neg_x_s1 ? -signed'(IDX_W'(cell_x)) : signed'(IDX_W'(cell_x));
		off_y  = neg_y_s1 ? -signed'(IDX_W'(cell_y)) : signed'(IDX_W'(cell_y));
		ix     = signed'(IDX_W'(center_x)) + off_x;
		iy     = signed'(IDX_W'(center_y)) + off_y;
		out_x  = ix[IDX_W-1] || (ix + IDX_W'(1) >= signed'(IDX_W'(grid_width)));
		out_y  = iy[IDX_W-1] || (iy + IDX_W'(1) >= signed'(IDX_W'(grid_height)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ctl_s2  <= '{query: ctl_s1.query, outside: !cfg_ok || out_x || out_y,
				wr_ok: ctl_s1.wr_ok};
			ix_s2   <= ix[COL_W-1:0];
			iy_s2   <= iy[ROW_W-1:0];
			t_s2    <= frac_x[POS_FRAC-1 -: FRACTION_BITS];
			u_s2    <= frac_y[POS_FRAC-1 -: FRACTION_BITS];
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			gain_s2 <= gain_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_ctl   = ctl_s2;
	assign out_ix    = ix_s2;
	assign out_iy    = iy_s2;
	assign out_t     = t_s2;
	assign out_u     = u_s2;
	assign out_col   = col_s2;
	assign out_row   = row_s2;
	assign out_gain  = gain_s2;

	a_no_query_write: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(ctl_s2.query && ctl_s2.wr_ok))
		else $error("item marked both as query and as table write");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2)
		else $error("stalled item dropped from stage 2");

endmodule

`default_nettype wire

@@ hdl/bgtl_table.sv @@
// gain table split into four banks by column and row parity, so all four
// corners of a cell are read in the same cycle; depends on bgtl_pkg
`default_nettype none

module bgtl_table #(
	parameter int MAX_COLS      = 64,
	parameter int MAX_ROWS      = 64,
	parameter int GAIN_BITS     = 16,
	parameter int FRACTION_BITS = 12,
	localparam int COL_W        = $clog2(MAX_COLS),
	localparam int ROW_W        = $clog2(MAX_ROWS)
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  bgtl_pkg::stage_ctl_t                  in_ctl,
	input  wire  [COL_W-1:0]                      in_ix,
	input  wire  [ROW_W-1:0]                      in_iy,
	input  wire  [FRACTION_BITS-1:0]              in_t,
	input  wire  [FRACTION_BITS-1:0]              in_u,
	input  wire  [bgtl_pkg::WIDX_W-1:0]           in_col,
	input  wire  [bgtl_pkg::WIDX_W-1:0]           in_row,
	input  wire  [GAIN_BITS-1:0]                  in_gain,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output bgtl_pkg::stage_ctl_t                  out_ctl,
	output logic                                  out_px,
	output logic                                  out_py,
	output logic [FRACTION_BITS-1:0]              out_t,
	output logic [FRACTION_BITS-1:0]              out_u,
	output logic [3:0][GAIN_BITS-1:0]             out_rd
);
	import bgtl_pkg::*;

	localparam int BC     = (MAX_COLS + 1) / 2;
	localparam int BR     = (MAX_ROWS + 1) / 2;
	localparam int BDEPTH = BC * BR;
	localparam int BA_W   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

	logic en_s3, v_s3, rd_en;
	logic [BA_W-1:0] waddr;
	stage_ctl_t ctl_s3;
	logic px_s3, py_s3;
	logic [FRACTION_BITS-1:0] t_s3, u_s3;
	logic [3:0][GAIN_BITS-1:0] rd_s3;

	assign en_s3    = !v_s3 || out_ready;
	assign in_ready = en_s3;
	assign rd_en    = en_s3 && in_valid && in_ctl.query;
	assign waddr    = BA_W'(32'(in_row >> 1) * BC + 32'(in_col >> 1));

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PC = 1'(b % 2);
		localparam logic PR = 1'(b / 2);

		logic [GAIN_BITS-1:0] bank_q [BDEPTH];
		logic [COL_W-1:0] c;
		logic [ROW_W-1:0] r;
		logic [BA_W-1:0]  raddr;
		logic             we;

		// the corner whose parity matches this bank is either ix or ix+1
		always_comb begin
			c     = (in_ix[0] == PC) ? in_ix : in_ix + COL_W'(1);
			r     = (in_iy[0] == PR) ? in_iy : in_iy + ROW_W'(1);
			raddr = BA_W'(32'(r >> 1) * BC + 32'(c >> 1));
			we    = en_s3 && in_valid && in_ctl.wr_ok &&
				(in_col[0] == PC) && (in_row[0] == PR);
		end

		always_ff @(posedge clk) begin
			if (we) begin
				bank_q[waddr] <= in_gain;
			end
			if (rd_en) begin
				rd_s3[b] <= bank_q[raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			// table writes end here
			v_s3 <= in_valid && in_ctl.query;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ctl_s3 <= in_ctl;
			px_s3  <= in_ix[0];
			py_s3  <= in_iy[0];
			t_s3   <= in_t;
			u_s3   <= in_u;
		end
	end

	assign out_valid = v_s3;
	assign out_ctl   = ctl_s3;
	assign out_px    = px_s3;
	assign out_py    = py_s3;
	assign out_t     = t_s3;
	assign out_u     = u_s3;
	assign out_rd    = rd_s3;

	a_query_reaches_s3: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_ctl.query |=> v_s3)
		else $error("accepted query missing after table read");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_ctl.query |=> !v_s3)
		else $error("table write produced a result");

endmodule

`default_nettype wire

@@ hdl/bgtl_blend.sv @@
// bilinear blend: corner products, row sums, column products, rounding and saturation
// depends on bgtl_pkg
`default_nettype none

module bgtl_blend #(
	parameter int GAIN_BITS     = 16,
	parameter int FRACTION_BITS = 12
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  bgtl_pkg::stage_ctl_t                  in_ctl,
	input  wire                                   in_px,
	input  wire                                   in_py,
	input  wire  [FRACTION_BITS-1:0]              in_t,
	input  wire  [FRACTION_BITS-1:0]              in_u,
	input  wire  [3:0][GAIN_BITS-1:0]             in_rd,
	input  wire  [bgtl_pkg::OUT_GAIN_W-1:0]       out_of_range_gain,
	output logic                                  m_tvalid,
	input  wire                                   m_tready,
	output logic [bgtl_pkg::OUT_GAIN_W-1:0]       gain,
	output logic                                  outside
);
	import bgtl_pkg::*;

	localparam int P_W = FRACTION_BITS + 1 + GAIN_BITS;
	localparam int S_W = 2 * FRACTION_BITS + 2 + GAIN_BITS;
	localparam logic [FRACTION_BITS:0] SCALE = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [S_W-1:0] HALF = S_W'(1) << (2 * FRACTION_BITS - 1);

	logic en_s4, en_s5, en_s6, en_s7;
	logic v_s4, v_s5, v_s6, v_s7;

	logic [FRACTION_BITS:0] st, su_s4, su_s5;
	logic [FRACTION_BITS:0] u_s4, u_s5;
	logic [1:0] i00, i10, i01, i11;
	logic [P_W-1:0] p00_s4, p10_s4, p01_s4, p11_s4;
	logic [P_W-1:0] a_s5, b_s5;
	logic [S_W-1:0] qa_s6, qb_s6, sum_r;
	logic [GAIN_BITS-1:0] g;
	logic o_s4, o_s5, o_s6;
	logic [OUT_GAIN_W-1:0] gain_s7;
	logic outside_s7;

	assign en_s7    = !v_s7 || m_tready;
	assign en_s6    = !v_s6 || en_s7;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	// map parity banks onto cell corners
	always_comb begin
		st  = SCALE - {1'b0, in_t};
		i00 = {in_py, in_px};
		i10 = {in_py, ~in_px};
		i01 = {~in_py, in_px};
		i11 = {~in_py, ~in_px};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= in_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			p00_s4 <= P_W'(st) * P_W'(in_rd[i00]);
			p10_s4 <= P_W'({1'b0, in_t}) * P_W'(in_rd[i10]);
			p01_s4 <= P_W'(st) * P_W'(in_rd[i01]);
			p11_s4 <= P_W'({1'b0, in_t}) * P_W'(in_rd[i11]);
			su_s4  <= SCALE - {1'b0, in_u};
			u_s4   <= {1'b0, in_u};
			o_s4   <= in_ctl.outside;
		end
		if (en_s5) begin
			a_s5  <= p00_s4 + p10_s4;
			b_s5  <= p01_s4 + p11_s4;
			su_s5 <= su_s4;
			u_s5  <= u_s4;
			o_s5  <= o_s4;
		end
		if (en_s6) begin
			qa_s6 <= S_W'(su_s5) * S_W'(a_s5);
			qb_s6 <= S_W'(u_s5) * S_W'(b_s5);
			o_s6  <= o_s5;
		end
		if (en_s7) begin
			gain_s7    <= o_s6 ? out_of_range_gain :
				((32'(g) > 32'({OUT_GAIN_W{1'b1}})) ? {OUT_GAIN_W{1'b1}} : OUT_GAIN_W'(g));
			outside_s7 <= o_s6;
		end
	end

	// round half up, then drop the fraction bits
	always_comb begin
		sum_r = qa_s6 + qb_s6 + HALF;
		g     = sum_r[2*FRACTION_BITS +: GAIN_BITS];
	end

	assign m_tvalid = v_s7;
	assign gain     = gain_s7;
	assign outside  = outside_s7;

	a_enter_s4: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s4)
		else $error("accepted query lost entering the blend");

endmodule

`default_nettype wire

@@ hdl/bilinear_gain_table_lookup_unit.sv @@
// Bilinear gain table lookup, top level: configuration registers, stream ports, pipeline.
// Pipeline: seven register stages, the first loaded by the input transaction itself;
// a query's result is valid on the output while it sits in the last of them.
// Throughput: one transaction per cycle unless m_tready stalls, set by the four parity
// banks that read all corners at once; table writes use a slot and give no result.
// Reset: valids and configuration registers return to defaults; table contents undefined.
// Depends on bgtl_pkg, bgtl_front, bgtl_table, bgtl_blend.
`default_nettype none

module bilinear_gain_table_lookup_unit #(
	parameter int MAX_COLS      = 64,
	parameter int MAX_ROWS      = 64,
	parameter int GAIN_BITS     = 16,
	parameter int FRACTION_BITS = 12
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// write_col[5:0], write_row[11:6], entry_gain[27:12], dir_x[43:28], dir_y[59:44], zero
	input  wire  [bgtl_pkg::S_TDATA_W-1:0]      s_tdata,
	// operation[0]
	input  wire                                 s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// gain[15:0]
	output logic [bgtl_pkg::M_TDATA_W-1:0]      m_tdata,
	// outside[0]
	output logic                                m_tuser,
	input  wire                                 cfg_we,
	input  wire  [bgtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [bgtl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bgtl_pkg::*;

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);

	logic [GRID_W-1:0]     grid_width_q, grid_height_q;
	logic [CTR_W-1:0]      center_x_q, center_y_q;
	logic [INV_W-1:0]      inv_x_q, inv_y_q;
	logic [OUT_GAIN_W-1:0] oor_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RST_GRID;
			grid_height_q <= RST_GRID;
			center_x_q    <= RST_CENTER;
			center_y_q    <= RST_CENTER;
			inv_x_q       <= RST_INV;
			inv_y_q       <= RST_INV;
			oor_gain_q    <= RST_OOR_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:    grid_width_q  <= cfg_data[GRID_W-1:0];
				REG_GRID_HEIGHT:   grid_height_q <= cfg_data[GRID_W-1:0];
				REG_CENTER_X:      center_x_q    <= cfg_data[CTR_W-1:0];
				REG_CENTER_Y:      center_y_q    <= cfg_data[CTR_W-1:0];
				REG_INV_SPACING_X: inv_x_q       <= cfg_data[INV_W-1:0];
				REG_INV_SPACING_Y: inv_y_q       <= cfg_data[INV_W-1:0];
				REG_OOR_GAIN:      oor_gain_q    <= cfg_data[OUT_GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic                     f_valid, f_ready;
	stage_ctl_t               f_ctl;
	logic [COL_W-1:0]         f_ix;
	logic [ROW_W-1:0]         f_iy;
	logic [FRACTION_BITS-1:0] f_t, f_u;
	logic [WIDX_W-1:0]        f_col, f_row;
	logic [GAIN_BITS-1:0]     f_gain;

	logic                      t_valid, t_ready;
	stage_ctl_t                t_ctl;
	logic                      t_px, t_py;
	logic [FRACTION_BITS-1:0]  t_t, t_u;
	logic [3:0][GAIN_BITS-1:0] t_rd;

	bgtl_front #(
		.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
		.GAIN_BITS(GAIN_BITS), .FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_op(s_tuser),
		.in_col(s_tdata[5:0]), .in_row(s_tdata[11:6]),
		.in_gain(s_tdata[27:12]),
		.in_dir_x(s_tdata[43:28]), .in_dir_y(s_tdata[59:44]),
		.grid_width(grid_width_q), .grid_height(grid_height_q),
		.center_x(center_x_q), .center_y(center_y_q),
		.inv_spacing_x(inv_x_q), .inv_spacing_y(inv_y_q),
		.out_valid(f_valid), .out_ready(f_ready),
		.out_ctl(f_ctl), .out_ix(f_ix), .out_iy(f_iy),
		.out_t(f_t), .out_u(f_u),
		.out_col(f_col), .out_row(f_row), .out_gain(f_gain)
	);

	bgtl_table #(
		.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS),
		.GAIN_BITS(GAIN_BITS), .FRACTION_BITS(FRACTION_BITS)
	) u_table (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready),
		.in_ctl(f_ctl), .in_ix(f_ix), .in_iy(f_iy),
		.in_t(f_t), .in_u(f_u),
		.in_col(f_col), .in_row(f_row), .in_gain(f_gain),
		.out_valid(t_valid), .out_ready(t_ready),
		.out_ctl(t_ctl), .out_px(t_px), .out_py(t_py),
		.out_t(t_t), .out_u(t_u), .out_rd(t_rd)
	);

	bgtl_blend #(
		.GAIN_BITS(GAIN_BITS), .FRACTION_BITS(FRACTION_BITS)
	) u_blend (
		.clk(clk), .arst_n(arst_n),
		.in_valid(t_valid), .in_ready(t_ready),
		.in_ctl(t_ctl), .in_px(t_px), .in_py(t_py),
		.in_t(t_t), .in_u(t_u), .in_rd(t_rd),
		.out_of_range_gain(oor_gain_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.gain(m_tdata), .outside(m_tuser)
	);

endmodule

`default_nettype wire

@@ tb/tb_bilinear_gain_table_lookup_unit.sv @@
// self-checking regression for bilinear_gain_table_lookup_unit: table writes and direction
// queries under random idling and back-pressure, checked against a shadow predictor
// depends on bgtl_pkg and the block's rtl only

class gain_table_shadow;
	localparam int COLS = 64;
	localparam int ROWS = 64;
	localparam int FRAC_BITS = 12;

	typedef struct packed {
		logic [15:0] gain;
		logic        outside;
	} lookup_t;

	logic [6:0]  grid_w;
	logic [6:0]  grid_h;
	logic [5:0]  ctr_x;
	logic [5:0]  ctr_y;
	logic [23:0] inv_x;
	logic [23:0] inv_y;
	logic [15:0] oor_gain;
	logic [15:0] gain_mem [COLS*ROWS];
	bit          claimed [COLS*ROWS];
	lookup_t     pending_gains [$];

	function new();
		grid_w   = bgtl_pkg::RST_GRID;
		grid_h   = bgtl_pkg::RST_GRID;
		ctr_x    = bgtl_pkg::RST_CENTER;
		ctr_y    = bgtl_pkg::RST_CENTER;
		inv_x    = bgtl_pkg::RST_INV;
		inv_y    = bgtl_pkg::RST_INV;
		oor_gain = bgtl_pkg::RST_OOR_GAIN;
	endfunction

	function int slot(int col, int row);
		return row * COLS + col;
	endfunction

	function void set_register(logic [2:0] idx, logic [23:0] val);
		case (idx)
		bgtl_pkg::REG_GRID_WIDTH:    grid_w = val[6:0];
		bgtl_pkg::REG_GRID_HEIGHT:   grid_h = val[6:0];
		bgtl_pkg::REG_CENTER_X:      ctr_x = val[5:0];
		bgtl_pkg::REG_CENTER_Y:      ctr_y = val[5:0];
		bgtl_pkg::REG_INV_SPACING_X: inv_x = val;
		bgtl_pkg::REG_INV_SPACING_Y: inv_y = val;
		bgtl_pkg::REG_OOR_GAIN:      oor_gain = val[15:0];
		default: ;
		endcase
	endfunction

	function bit settings_ok();
		return grid_w >= 1 && grid_w <= COLS && grid_h >= 1 && grid_h <= ROWS &&
			ctr_x < grid_w && ctr_y < grid_h;
	endfunction

	// signed product carries 23 fraction bits; arithmetic shift floors it
	function longint axis_cell(logic [15:0] dir, logic [23:0] inv, output logic [11:0] frac);
		longint pos;
		pos = longint'($signed(dir)) * longint'(inv);
		frac = pos[22:11];
		return pos >>> 23;
	endfunction

	function bit locate(logic [15:0] dx, logic [15:0] dy, output int col, output int row,
			output logic [11:0] t, output logic [11:0] u);
		longint cx;
		longint cy;
		longint lim_x;
		longint lim_y;
		cx = axis_cell(dx, inv_x, t);
		cy = axis_cell(dy, inv_y, u);
		cx = cx + longint'(ctr_x);
		cy = cy + longint'(ctr_y);
		lim_x = grid_w;
		lim_y = grid_h;
		lim_x = lim_x - 2;
		lim_y = lim_y - 2;
		col = int'(cx);
		row = int'(cy);
		return settings_ok() && cx >= 0 && cx <= lim_x && cy >= 0 && cy <= lim_y;
	endfunction

	function void claim(int col, int row);
		claimed[slot(col, row)] = 1'b1;
	endfunction

	function bit is_claimed(int col, int row);
		return claimed[slot(col, row)];
	endfunction

	function void accept_item(logic op, logic [63:0] d);
		logic [11:0] t;
		logic [11:0] u;
		int          col;
		int          row;
		longint      s, lt, lu, g00, g10, g01, g11, a, b, total, g;
		lookup_t     res;
		if (op == bgtl_pkg::OP_WRITE) begin
			gain_mem[slot(int'(d[5:0]), int'(d[11:6]))] = d[27:12];
			return;
		end
		res.outside = !locate(d[43:28], d[59:44], col, row, t, u);
		if (res.outside) begin
			res.gain = oor_gain;
		end else begin
			s = 64'd1 << FRAC_BITS;
			lt = t;
			lu = u;
			g00 = gain_mem[slot(col, row)];
			g10 = gain_mem[slot(col + 1, row)];
			g01 = gain_mem[slot(col, row + 1)];
			g11 = gain_mem[slot(col + 1, row + 1)];
			a = (s - lt) * g00 + lt * g10;
			b = (s - lt) * g01 + lt * g11;
			total = (s - lu) * a + lu * b;
			g = (total + (64'd1 << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
			res.gain = (g > 65535) ? 16'hFFFF : g[15:0];
		end
		pending_gains.push_back(res);
	endfunction

	function string match_result(logic [15:0] gain, logic outside);
		lookup_t want;
		string   msg;
		if (pending_gains.size() == 0)
			return $sformatf("result with nothing pending: gain %h outside %b", gain, outside);
		want = pending_gains.pop_front();
		msg = "";
		if (gain !== want.gain)
			msg = $sformatf("gain %h, expected %h;", gain, want.gain);
		if (outside !== want.outside)
			msg = {msg, $sformatf(" outside %b, expected %b", outside, want.outside)};
		return msg;
	endfunction
endclass

module tb_bilinear_gain_table_lookup_unit;
	import bgtl_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gain_table_shadow shadow;
	string            verdict;
	int               mismatches = 0;
	int               cycle_count = 0;
	int               rx_hold = 0;
	bit               calm_tx = 1'b0;
	bit               calm_rx = 1'b0;

	bilinear_gain_table_lookup_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("bilinear_gain_table_lookup_unit regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// both handshakes are sampled here, inputs before outputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				shadow.accept_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				verdict = shadow.match_result(m_tdata, m_tuser);
				if (verdict != "")
					report_mismatch(verdict);
			end
		end
	end

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 7))
		0: return 16'h0000;
		1: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_dir();
		case ($urandom_range(0, 7))
		0: return 16'h8000;
		1: return 16'h7FFF;
		2: return 16'h0000;
		3: return 16'($urandom_range(0, 1023) - 512);
		default: return 16'($urandom);
		endcase
	endfunction

	// sometimes sets the unused upper bits of a register write
	function automatic logic [23:0] with_noise(logic [23:0] v, int w);
		if ($urandom_range(0, 3) == 0)
			return v | 24'($urandom << w);
		return v;
	endfunction

	// receiver: random stalls, with calm stretches
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready = 1'b0;
				rx_hold--;
			end else begin
				m_tready = 1'b1;
				if (!calm_rx && $urandom_range(0, 3) == 0)
					rx_hold = pick_gap(1'b0);
			end
		end
	end

	// every driving task starts and ends just after a falling edge
	task automatic send_item(logic op, logic [5:0] col, logic [5:0] row, logic [15:0] g,
			logic [15:0] dx, logic [15:0] dy);
		int gap;
		gap = pick_gap(calm_tx);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {4'b0, dy, dx, g, row, col};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_write(int col, int row, logic [15:0] g);
		shadow.claim(col, row);
		send_item(OP_WRITE, 6'(col), 6'(row), g, 16'($urandom), 16'($urandom));
	endtask

	// a query whose cell is in range first gets any unwritten corner filled
	task automatic send_query(logic [15:0] dx, logic [15:0] dy);
		int          col;
		int          row;
		logic [11:0] t;
		logic [11:0] u;
		if (shadow.locate(dx, dy, col, row, t, u)) begin
			for (int dr = 0; dr < 2; dr++)
				for (int dc = 0; dc < 2; dc++)
					if (!shadow.is_claimed(col + dc, row + dr))
						send_write(col + dc, row + dr, pick_gain());
		end
		send_item(OP_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), dx, dy);
	endtask

	task automatic wait_results();
		s_tvalid = 1'b0;
		while (shadow.pending_gains.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow.set_register(idx, val);
	endtask

	// writes with no result may still be in flight, hence the extra cycles
	task automatic load_settings(int w, int h, int cx, int cy, logic [23:0] ivx,
			logic [23:0] ivy, logic [15:0] oor);
		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(REG_GRID_WIDTH, with_noise(24'(w), GRID_W));
		write_reg(REG_GRID_HEIGHT, with_noise(24'(h), GRID_W));
		write_reg(REG_CENTER_X, with_noise(24'(cx), CTR_W));
		write_reg(REG_CENTER_Y, with_noise(24'(cy), CTR_W));
		write_reg(REG_INV_SPACING_X, ivx);
		write_reg(REG_INV_SPACING_Y, ivy);
		write_reg(REG_OOR_GAIN, with_noise(24'(oor), OUT_GAIN_W));
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNMAPPED, 24'($urandom));
	endtask

	function automatic int pick_size();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(2, 64);
		case ($urandom_range(0, 2))
		0: return 0;
		1: return 1;
		default: return $urandom_range(65, 127);
		endcase
	endfunction

	function automatic int pick_center(int size);
		if (size < 1 || size > 64 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 63);
		return $urandom_range(0, size - 1);
	endfunction

	function automatic logic [23:0] pick_spacing(int size);
		case ($urandom_range(0, 9))
		0: return 24'd0;
		1: return 24'hFFFFFF;
		2: return 24'($urandom);
		default: return 24'($urandom_range(0, (size > 64 ? 64 : size) * 256));
		endcase
	endfunction

	task automatic random_settings();
		int w;
		int h;
		w = pick_size();
		h = pick_size();
		load_settings(w, h, pick_center(w), pick_center(h), pick_spacing(w), pick_spacing(h),
			16'($urandom));
	endtask

	task automatic run_items(int n, bit hold_midway);
		int col;
		int row;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 24) == 0)
				calm_tx = !calm_tx;
			if ($urandom_range(0, 24) == 0)
				calm_rx = !calm_rx;
			if ((hold_midway && i == n / 2) || $urandom_range(0, 79) == 0)
				wait_results();
			if ($urandom_range(0, 99) < 35) begin
				if (shadow.grid_w >= 1 && shadow.grid_w <= 64 && $urandom_range(0, 3) != 0)
					col = $urandom_range(0, shadow.grid_w - 1);
				else
					col = $urandom_range(0, 63);
				if (shadow.grid_h >= 1 && shadow.grid_h <= 64 && $urandom_range(0, 3) != 0)
					row = $urandom_range(0, shadow.grid_h - 1);
				else
					row = $urandom_range(0, 63);
				send_write(col, row, pick_gain());
			end else begin
				send_query(pick_dir(), pick_dir());
			end
		end
	endtask

	initial begin
		shadow = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WRITE;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_WIDTH;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: table corners, a saturating cell, extreme directions
		send_write(0, 0, 16'hFFFF);
		send_write(63, 63, 16'h0000);
		send_write(63, 0, 16'h8000);
		send_write(0, 63, 16'h0001);
		send_write(32, 32, 16'hFFFF);
		send_write(33, 32, 16'hFFFF);
		send_write(32, 33, 16'hFFFF);
		send_write(33, 33, 16'hFFFF);
		send_query(16'h4000, 16'h2000);
		send_query(16'h0000, 16'h0000);
		send_query(16'h7FFF, 16'h7FFF);
		// most negative lands exactly on a cell boundary
		send_query(16'h8000, 16'h8000);
		// just below zero floors into the lower cell
		send_query(16'hFFFF, 16'h0001);
		send_query(16'h8000, 16'h7FFF);

		// invalid sizes, centre at its size, zero and full spacing, tiny grids, edge centre
		load_settings(0, 64, 0, 32, 24'd256, 24'd256, 16'hFFFF);
		run_items(15, 1'b1);
		load_settings(64, 127, 32, 32, 24'd256, 24'd256, 16'h5A5A);
		run_items(15, 1'b0);
		load_settings(10, 10, 10, 3, 24'd2560, 24'd2560, 16'h00FF);
		run_items(15, 1'b0);
		load_settings(64, 64, 5, 60, 24'd0, 24'd0, 16'h1234);
		run_items(15, 1'b0);
		load_settings(64, 64, 32, 32, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		run_items(15, 1'b0);
		load_settings(2, 2, 0, 0, 24'd200, 24'd200, 16'h0000);
		run_items(15, 1'b0);
		load_settings(1, 1, 0, 0, 24'd256, 24'd256, 16'hBEEF);
		run_items(15, 1'b0);
		load_settings(64, 64, 63, 63, 24'd8192, 24'd8192, 16'h0000);
		run_items(20, 1'b0);

		for (int p = 0; p < 9; p++) begin
			random_settings();
			calm_tx = ($urandom_range(0, 3) == 0);
			calm_rx = ($urandom_range(0, 3) == 0);
			run_items(55, p == 0);
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("bilinear_gain_table_lookup_unit regression: pass");
		else
			$display("bilinear_gain_table_lookup_unit regression: fail");
		$finish;
	end
endmodule
